@@ hw/rtl/dadsr_pkg.sv @@
// Package for the DADSR envelope generator: word types, stage codes,
// level constants and the shared linear ramp function. No dependencies.
package dadsr_pkg;

  localparam int unsigned LevelW = 25;
  localparam int unsigned DelayW = 18;
  localparam int unsigned NoteW  = 7;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 25;

  // Levels in unsigned fixed point, 1.0 = 2^24
  localparam logic [LevelW-1:0] LevelOne   = 25'd16777216;
  localparam logic [LevelW-1:0] AttackDone = 25'd16775538;
  localparam logic [LevelW-1:0] DecayNear  = 25'd8389;
  localparam logic [LevelW-1:0] LowEps     = 25'd1678;

  localparam logic [LevelW-1:0] AmpAttackStep  = 25'd69905;
  localparam logic [LevelW-1:0] AmpReleaseStep = 25'd11651;

  localparam logic [NoteW-1:0] HeldNoteRst = 7'd60;

  typedef enum logic [2:0] {
    StIdle    = 3'd0,
    StDelay   = 3'd1,
    StAttack  = 3'd2,
    StDecay   = 3'd3,
    StSustain = 3'd4,
    StRelease = 3'd5
  } dadsr_stage_e;

  typedef enum logic [1:0] {
    ActTick    = 2'd0,
    ActNoteOn  = 2'd1,
    ActNoteOff = 2'd2,
    ActAllOff  = 2'd3
  } dadsr_action_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegAttackStep   = 3'd0,
    RegDecayStep    = 3'd1,
    RegSustainLevel = 3'd2,
    RegReleaseStep  = 3'd3,
    RegDelaySamples = 3'd4,
    RegEnvReset     = 3'd5,
    RegFilterEnable = 3'd6
  } dadsr_reg_e;

  typedef struct packed {
    logic [1:0]       action;
    logic [NoteW-1:0] note;
  } dadsr_in_t;

  typedef struct packed {
    logic [LevelW-1:0] filter_level;
    logic [LevelW-1:0] amp_level;
    logic [2:0]        env_stage;
    logic              sounding;
  } dadsr_out_t;

  typedef struct packed {
    logic [LevelW-1:0] attack_step;
    logic [LevelW-1:0] decay_step;
    logic [LevelW-1:0] sustain_level;
    logic [LevelW-1:0] release_step;
    logic [DelayW-1:0] delay_samples;
    logic              env_reset;
    logic              filter_enable;
  } dadsr_cfg_t;

  typedef struct packed {
    logic [LevelW-1:0] filter_acc;
    logic [LevelW-1:0] amp_acc;
    dadsr_stage_e      stage;
    logic [DelayW-1:0] delay_left;
    logic              gate_on;
    logic [NoteW-1:0]  held_note;
    logic              pitch_valid;
  } dadsr_state_t;

  // Linear ramp toward target, clamped at the target.
  function automatic logic [LevelW-1:0] ramp(input logic [LevelW-1:0] cur,
                                             input logic [LevelW-1:0] target,
                                             input logic [LevelW-1:0] step);
    logic [LevelW:0] sum;
    logic [LevelW:0] lim;
    logic [LevelW-1:0] res;
    sum = {1'b0, cur} + {1'b0, step};
    lim = {1'b0, target} + {1'b0, step};
    if (cur < target) begin
      res = (sum > {1'b0, target}) ? target : sum[LevelW-1:0];
    end else if ({1'b0, cur} < lim) begin
      res = target;
    end else begin
      res = cur - step;
    end
    return res;
  endfunction

  // Zero step jumps straight to the target.
  function automatic logic [LevelW-1:0] filter_ramp(input logic [LevelW-1:0] cur,
                                                    input logic [LevelW-1:0] target,
                                                    input logic [LevelW-1:0] step);
    logic [LevelW-1:0] res;
    if (step == '0) begin
      res = target;
    end else begin
      res = ramp(cur, target, step);
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/dadsr_envelope_generator_unit.sv @@
// Top level of the DADSR envelope generator: input register, config
// registers, envelope state and result register. Depends on dadsr_pkg, dadsr_step.
//
//  channel | dir | handshake              | word
//  --------+-----+------------------------+-----------------------------
//  in      | in  | in_valid_i / in_stall_o | action, note
//  out     | out | out_valid_o/ out_stall_i| filter_level, amp_level,
//          |     |                         | env_stage, sounding
//  cfg     | in  | cfg_we_i (no wait)      | cfg_index_i, cfg_data_i
//
// One word per cycle sustained while out_stall_i stays low. A word waits in the
// input register, then a single pass of dadsr_step updates the envelope state and
// loads the result register, which drives out_valid_o until the result is taken.
// Reset restores config defaults and clears state (held note 60, stage idle).
// A stalled result holds; the input register keeps taking words while the
// result register is free or being drained in the same cycle.
module dadsr_envelope_generator_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  dadsr_pkg::dadsr_in_t                 in_word_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output dadsr_pkg::dadsr_out_t                out_word_o,
  input  logic                                 cfg_we_i,
  input  logic [dadsr_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [dadsr_pkg::CfgDataW-1:0]       cfg_data_i
);
  import dadsr_pkg::*;

  logic         item_valid_q;
  dadsr_in_t    item_q;
  logic         out_valid_q;
  dadsr_out_t   out_q;
  dadsr_cfg_t   cfg_q;
  dadsr_state_t state_q, state_d;
  dadsr_out_t   result_d;
  logic         proc_go;
  logic         in_take;

  // process the held word when the result register can take it
  assign proc_go    = item_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = item_valid_q && !proc_go;
  assign in_take    = in_valid_i && !in_stall_o;

  dadsr_step u_step (
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .item_i  (item_q),
    .state_o (state_d),
    .result_o(result_d)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_take) begin
      item_valid_q <= 1'b1;
    end else if (proc_go) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) item_q <= in_word_i;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_go) out_q <= result_d;
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_step   <= 25'd34953;
      cfg_q.decay_step    <= 25'd3495;
      cfg_q.sustain_level <= LevelOne;
      cfg_q.release_step  <= 25'd3495;
      cfg_q.delay_samples <= '0;
      cfg_q.env_reset     <= 1'b1;
      cfg_q.filter_enable <= 1'b0;
    end else if (cfg_we_i) begin
      case (dadsr_reg_e'(cfg_index_i))
        RegAttackStep:   cfg_q.attack_step   <= cfg_data_i[LevelW-1:0];
        RegDecayStep:    cfg_q.decay_step    <= cfg_data_i[LevelW-1:0];
        RegSustainLevel: cfg_q.sustain_level <= cfg_data_i[LevelW-1:0];
        RegReleaseStep:  cfg_q.release_step  <= cfg_data_i[LevelW-1:0];
        RegDelaySamples: cfg_q.delay_samples <= cfg_data_i[DelayW-1:0];
        RegEnvReset:     cfg_q.env_reset     <= cfg_data_i[0];
        RegFilterEnable: cfg_q.filter_enable <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // envelope state; disabling the filter envelope parks it at idle unless a word is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.filter_acc  <= '0;
      state_q.amp_acc     <= '0;
      state_q.stage       <= StIdle;
      state_q.delay_left  <= '0;
      state_q.gate_on     <= 1'b0;
      state_q.held_note   <= HeldNoteRst;
      state_q.pitch_valid <= 1'b0;
    end else if (proc_go) begin
      state_q <= state_d;
    end else if (cfg_we_i && dadsr_reg_e'(cfg_index_i) == RegFilterEnable
                 && !cfg_data_i[0]) begin
      state_q.filter_acc <= '0;
      state_q.stage      <= StIdle;
      state_q.delay_left <= '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

@@ hw/rtl/dadsr_step.sv @@
// Next-state logic for one item: amplitude ramp, filter DADSR stages and
// note handling, plus the result word. Depends on dadsr_pkg.
module dadsr_step (
  input  dadsr_pkg::dadsr_state_t state_i,
  input  dadsr_pkg::dadsr_cfg_t   cfg_i,
  input  dadsr_pkg::dadsr_in_t    item_i,
  output dadsr_pkg::dadsr_state_t state_o,
  output dadsr_pkg::dadsr_out_t   result_o
);
  import dadsr_pkg::*;

  logic [LevelW-1:0] sus;
  logic [LevelW-1:0] amp_ramp;
  logic [LevelW-1:0] filt_ramp;
  logic [LevelW-1:0] diff;
  logic [LevelW-1:0] ramp_target;
  logic [LevelW-1:0] ramp_step;
  logic [DelayW-1:0] delay_dec;

  assign sus = (cfg_i.sustain_level > LevelOne) ? LevelOne : cfg_i.sustain_level;

  assign amp_ramp = ramp(state_i.amp_acc,
                         state_i.gate_on ? LevelOne : '0,
                         state_i.gate_on ? AmpAttackStep : AmpReleaseStep);

  // one shared filter ramp, target and step picked by stage
  always_comb begin
    case (state_i.stage)
      StAttack: begin
        ramp_target = LevelOne;
        ramp_step   = cfg_i.attack_step;
      end
      StDecay: begin
        ramp_target = sus;
        ramp_step   = cfg_i.decay_step;
      end
      default: begin
        ramp_target = '0;
        ramp_step   = cfg_i.release_step;
      end
    endcase
  end

  assign filt_ramp = filter_ramp(state_i.filter_acc, ramp_target, ramp_step);
  assign diff      = (filt_ramp > sus) ? filt_ramp - sus : sus - filt_ramp;
  assign delay_dec = (state_i.delay_left != '0) ? state_i.delay_left - DelayW'(1)
                                                : state_i.delay_left;

  // next state
  always_comb begin
    state_o = state_i;
    case (dadsr_action_e'(item_i.action))
      ActTick: begin
        state_o.amp_acc = amp_ramp;
        if (!state_i.gate_on && amp_ramp <= LowEps) begin
          state_o.amp_acc     = '0;
          state_o.pitch_valid = 1'b0;
        end
        if (cfg_i.filter_enable) begin
          case (state_i.stage)
            StDelay: begin
              state_o.delay_left = delay_dec;
              if (delay_dec == '0) state_o.stage = StAttack;
            end
            StAttack: begin
              state_o.filter_acc = filt_ramp;
              if (filt_ramp >= AttackDone) begin
                state_o.filter_acc = LevelOne;
                state_o.stage      = StDecay;
              end
            end
            StDecay: begin
              state_o.filter_acc = filt_ramp;
              if (diff <= DecayNear) begin
                state_o.filter_acc = sus;
                state_o.stage      = StSustain;
              end
            end
            StSustain: state_o.filter_acc = sus;
            StRelease: begin
              state_o.filter_acc = filt_ramp;
              if (filt_ramp <= LowEps) begin
                state_o.filter_acc = '0;
                state_o.stage      = StIdle;
              end
            end
            default: state_o.filter_acc = '0;
          endcase
        end
      end
      ActNoteOn: begin
        state_o.held_note   = item_i.note;
        state_o.pitch_valid = 1'b1;
        state_o.gate_on     = 1'b1;
        if (cfg_i.env_reset) state_o.filter_acc = '0;
        state_o.delay_left = cfg_i.delay_samples;
        state_o.stage = (cfg_i.delay_samples != '0) ? StDelay : StAttack;
      end
      ActNoteOff: begin
        if (state_i.gate_on && item_i.note == state_i.held_note) begin
          state_o.gate_on = 1'b0;
          state_o.stage   = StRelease;
        end
      end
      default: begin
        state_o.gate_on     = 1'b0;
        state_o.amp_acc     = '0;
        state_o.filter_acc  = '0;
        state_o.stage       = StIdle;
        state_o.delay_left  = '0;
        state_o.pitch_valid = 1'b0;
      end
    endcase
  end

  // result word, taken after the item
  always_comb begin
    result_o.filter_level = state_o.filter_acc;
    result_o.amp_level    = state_o.amp_acc;
    result_o.env_stage    = state_o.stage;
    result_o.sounding     = state_o.pitch_valid && (state_o.amp_acc != '0);
  end

endmodule
